// ===== rtl/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int ADDR_W  = $clog2(CELLS);

   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] NULL_CODE    = 8'd0;
   localparam logic [7:0] RESET_ATTR   = 8'd7;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [2:0] KIND_NOP     = 3'd0;
   localparam logic [2:0] KIND_CHAR    = 3'd1;
   localparam logic [2:0] KIND_NEWLINE = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_READ    = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  code;
      logic [10:0] address;
   } cmd_type;

endpackage

// ===== rtl/tcw_front.sv =====
// Front end: accepts transactions, classifies them and queues commands.
module tcw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_op,
   input  logic [7:0]           req_char_code,
   input  logic [10:0]          req_read_address,
   input  logic                 init_busy,
   output logic                 cmd_valid,
   output tcw_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);

   tcw_pkg::cmd_type q_ff [2];
   tcw_pkg::cmd_type new_cmd;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push_ok;

   always_comb begin
      new_cmd.code    = req_char_code;
      new_cmd.address = req_read_address;
      unique case (req_op)
         tcw_pkg::OP_PUT: begin
            if (req_char_code == tcw_pkg::NULL_CODE) new_cmd.kind = tcw_pkg::KIND_NOP;
            else if (req_char_code == tcw_pkg::NEWLINE_CODE)
               new_cmd.kind = tcw_pkg::KIND_NEWLINE;
            else new_cmd.kind = tcw_pkg::KIND_CHAR;
         end
         tcw_pkg::OP_CLEAR: new_cmd.kind = tcw_pkg::KIND_CLEAR;
         tcw_pkg::OP_READ:  new_cmd.kind = tcw_pkg::KIND_READ;
         default:           new_cmd.kind = tcw_pkg::KIND_NOP;
      endcase
   end

   assign req_full  = (count_ff == 2'd2) || init_busy;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push_ok) q_ff[wr_ptr_ff] <= new_cmd;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("command popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("command queue count overflow");
   a_no_push_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |=> $stable(wr_ptr_ff) || !$past(init_busy))
      else $error("command accepted during clearing pass");

endmodule

// ===== rtl/tcw_back.sv =====
// Back end: cell store, cursor, scroll and clear sequencer, result register.
module tcw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [7:0]           csr_write_data,
   input  logic                 cmd_valid,
   input  tcw_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 init_busy,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [10:0]          rsp_cursor_position,
   output logic [7:0]           rsp_cell_char,
   output logic [7:0]           rsp_cell_attribute
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCRRD = 3'd1;
   localparam logic [2:0] S_SCRWR = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL  = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
   localparam logic [tcw_pkg::ADDR_W-1:0] LAST_ROW0  =
      tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A     = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL   = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROWN  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

   logic [15:0] mem [tcw_pkg::CELLS];
   logic [15:0] rdata_ff;

   logic [2:0]                  state_ff, state_in;
   logic [tcw_pkg::ADDR_W-1:0]  idx_ff, idx_in;
   logic [7:0]                  fattr_ff, fattr_in;
   logic                        init_ff, init_in;
   logic                        rdsel_ff, rdsel_in;
   logic [tcw_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [7:0]                  text_attr_ff, fill_attr_ff;
   logic                        rvalid_ff;
   logic [10:0]                 rpos_ff;
   logic [7:0]                  rchar_ff, rattr_ff;

   logic                        we;
   logic [tcw_pkg::ADDR_W-1:0]  waddr, raddr, cur_pos;
   logic [15:0]                 wdata;
   logic                        in_range;
   logic                        emit;

   assign cur_pos   = tcw_pkg::ADDR_W'(row_ff * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(col_ff);
   assign in_range  = 32'(cmd.address) < tcw_pkg::CELLS;
   assign init_busy = init_ff;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid && !rvalid_ff && !init_ff;
   assign emit      = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      fattr_in = fattr_ff;
      init_in  = init_ff;
      rdsel_in = rdsel_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = {fattr_ff, tcw_pkg::SPACE_CODE};
      raddr    = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            raddr = tcw_pkg::ADDR_W'(cmd.address);
            if (cmd_pop) begin
               rdsel_in = 1'b0;
               state_in = S_DONE;
               case (cmd.kind) inside
                  tcw_pkg::KIND_CHAR, tcw_pkg::KIND_NEWLINE: begin
                     if (cmd.kind == tcw_pkg::KIND_CHAR) begin
                        we    = 1'b1;
                        waddr = cur_pos;
                        wdata = {text_attr_ff, cmd.code};
                     end
                     if (cmd.kind == tcw_pkg::KIND_CHAR && col_ff != LAST_COL) begin
                        col_in = col_ff + 1'b1;
                     end else begin
                        col_in = '0;
                        if (row_ff == LAST_ROWN) begin
                           idx_in   = COLS_A;
                           state_in = S_SCRRD;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end
                  end
                  tcw_pkg::KIND_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     idx_in   = '0;
                     fattr_in = text_attr_ff;
                     state_in = S_FILL;
                  end
                  tcw_pkg::KIND_READ: rdsel_in = in_range;
                  default: ;
               endcase
            end
         end
         S_SCRRD: state_in = S_SCRWR;
         S_SCRWR: begin
            we    = 1'b1;
            waddr = idx_ff - COLS_A;
            wdata = rdata_ff;
            if (idx_ff == LAST_CELL) begin
               idx_in   = LAST_ROW0;
               fattr_in = fill_attr_ff;
               state_in = S_FILL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCRRD;
            end
         end
         S_FILL: begin
            we = 1'b1;
            if (idx_ff == LAST_CELL) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      rdsel_ff <= rdsel_in;
      if (emit) begin
         rpos_ff  <= 11'(cur_pos);
         rchar_ff <= rdsel_ff ? rdata_ff[7:0]  : 8'd0;
         rattr_ff <= rdsel_ff ? rdata_ff[15:8] : 8'd0;
      end
      if (reset) begin
         state_ff     <= S_FILL;
         idx_ff       <= '0;
         fattr_ff     <= tcw_pkg::RESET_ATTR;
         init_ff      <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         text_attr_ff <= tcw_pkg::RESET_ATTR;
         fill_attr_ff <= tcw_pkg::RESET_ATTR;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         fattr_ff <= fattr_in;
         init_ff  <= init_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (csr_write_enable && !csr_index) text_attr_ff <= csr_write_data;
         if (csr_write_enable &&  csr_index) fill_attr_ff <= csr_write_data;
         if (emit) rvalid_ff <= 1'b1;
         else if (rsp_pop) rvalid_ff <= 1'b0;
      end
   end

   assign rsp_empty           = !rvalid_ff;
   assign rsp_cursor_position = rpos_ff;
   assign rsp_cell_char       = rchar_ff;
   assign rsp_cell_attribute  = rattr_ff;

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !rvalid_ff) else $error("command started with result slot full");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < tcw_pkg::ROWS) else $error("cursor row out of range");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < tcw_pkg::COLUMNS) else $error("cursor column out of range");
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      we |-> 32'(waddr) < tcw_pkg::CELLS) else $error("cell write out of range");
   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      emit |=> !emit) else $error("result emitted twice");

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer.
// Text console of 80x25 cells. After reset a clearing pass writes every cell, one per cycle,
// and full stays high meanwhile. A put, newline, read or ignored code is popped in the idle
// state and its result is registered from the done state; the back end starts the next
// command only once the result has been popped. A clear runs the fill state over every cell,
// and a put or newline that scrolls alternates read and write states, then fills the last row:
// each moved cell needs a read and then a write of the cell store, and the blank row and
// the clear write one cell per cycle. A two-entry command queue takes new transactions
// while the back end works; one result register holds the answer until it is popped.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_read_address,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [10:0] rsp_cursor_position,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_attribute,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   tcw_pkg::cmd_type cmd;
   logic             cmd_valid, cmd_pop, init_busy;

   tcw_front u_front (
      .clock, .reset, .req_push, .req_full, .req_op, .req_char_code, .req_read_address,
      .init_busy, .cmd_valid, .cmd, .cmd_pop
   );

   tcw_back u_back (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .cmd_valid, .cmd, .cmd_pop, .init_busy, .rsp_empty, .rsp_pop,
      .rsp_cursor_position, .rsp_cell_char, .rsp_cell_attribute
   );

endmodule
